FILE: rtl/core/dep_pkg.sv
`default_nettype none
package dep_pkg;

	localparam int unsigned POS_W = 8;

	typedef enum logic [2:0] {
		PH_PREAMBLE,
		PH_MAGIC,
		PH_HEADER,
		PH_VALUE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_PIXEL,
		KIND_PAPYRUS,
		KIND_NO_MAGIC
	} kind_t;

	typedef enum logic [1:0] {
		FORM_IMPLICIT,
		FORM_LONG,
		FORM_SHORT
	} form_t;

	typedef struct packed {
		kind_t             kind;
		logic [15:0]       tag_group;
		logic [15:0]       tag_element;
		logic [1:0]        length_form;
		logic [31:0]       value_length;
		logic [7:0]        pixel_byte;
		logic              last_pixel;
		logic [4:0][15:0]  cap;
	} result_t;

	localparam logic [31:0] LEN_UNDEF   = 32'hFFFF_FFFF;
	localparam logic [15:0] ITEM_GROUP  = 16'hFFFE;
	localparam logic [15:0] ITEM_ELEM   = 16'hE000;
	localparam logic [15:0] IMAGE_GROUP = 16'h0028;
	localparam logic [15:0] PIXEL_GROUP = 16'h7FE0;
	localparam logic [15:0] PIXEL_ELEM  = 16'h0010;

	// rows, columns, samples, bits allocated, pixel representation
	localparam logic [0:4][15:0] CAP_ELEMS = '{16'h0010, 16'h0011, 16'h0002, 16'h0100, 16'h0103};

	// last entry pads the table to a power of two and is never compared
	localparam logic [0:7][7:0] PAPYRUS_TXT = '{"P", "A", "P", "Y", "R", "U", "S", 8'h00};
	localparam logic [0:3][7:0] MAGIC_TXT   = '{"D", "I", "C", "M"};

	function automatic logic [7:0] fold_upper(input logic [7:0] b);
		return (b >= "a" && b <= "z") ? b - 8'd32 : b;
	endfunction

	function automatic form_t form_of(input logic [15:0] rep);
		logic [7:0] c0;
		logic [7:0] c1;
		logic       up0;
		logic       up1;
		c0  = rep[7:0];
		c1  = rep[15:8];
		up0 = c0 >= "A" && c0 <= "Z";
		up1 = c1 >= "A" && c1 <= "Z";
		if ((!up0 || !up1) && !(c0 == " " && c1 != 8'h00))
			return FORM_IMPLICIT;
		if ((c0 == "O" && c1 == "B") || (c0 == "O" && c1 == "W") ||
		    (c0 == "S" && c1 == "Q") || (c0 == "U" && c1 == "N"))
			return FORM_LONG;
		return FORM_SHORT;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dep_parse_core.sv
`default_nettype none
module dep_parse_core #(
	parameter int PREAMBLE_BYTES = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      byte_in,
	output logic                 emit,
	output dep_pkg::result_t     res
);
	import dep_pkg::*;

	localparam logic [8:0] PRE_LEN  = 9'(PREAMBLE_BYTES);
	localparam logic       PAPY_EN  = PREAMBLE_BYTES >= 7;
	localparam phase_t     PH_RESET = (PREAMBLE_BYTES == 0) ? PH_MAGIC : PH_PREAMBLE;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic              pm_q, pm_d;
	logic [15:0]       grp_q, grp_d;
	logic [15:0]       elem_q, elem_d;
	logic [15:0]       rep_q, rep_d;
	logic [31:0]       len_q, len_d;
	logic [31:0]       rem_q, rem_d;
	logic [15:0]       fv_q, fv_d;
	logic [1:0]        off_q, off_d;
	logic [4:0][15:0]  cap_q, cap_d;

	logic [7:0]  fold;
	logic        pre_last;
	logic        pm_pre;
	logic        pm_mag;
	form_t       form_cur;
	logic        hdr_end;
	logic        skip;
	logic        go_value;
	logic [31:0] rem_dec;
	logic        val_done;
	logic        is_pixel;
	logic        emit_d;
	kind_t       kind_d;
	logic [7:0]  pix_d;
	logic        last_d;

	assign fold     = fold_upper(byte_in);
	assign pre_last = ({1'b0, pos_q} + 9'd1) >= PRE_LEN;
	assign pm_pre   = pm_q & ~(pos_q < 8'd7 && fold != PAPYRUS_TXT[pos_q[2:0]]);
	assign pm_mag   = pm_q & (fold == MAGIC_TXT[pos_q[1:0]]);
	assign form_cur = form_of(rep_q);
	assign hdr_end  = (form_cur == FORM_LONG) ? (pos_q == 8'd11) : (pos_q == 8'd7);
	assign skip     = len_d == LEN_UNDEF || (grp_q == ITEM_GROUP && elem_q == ITEM_ELEM);
	assign go_value = hdr_end && !skip && len_d != 32'd0;
	assign rem_dec  = rem_q - 32'd1;
	assign val_done = rem_dec == 32'd0;
	assign is_pixel = grp_q == PIXEL_GROUP && elem_q == PIXEL_ELEM;

	// header length assembly
	always_comb begin
		len_d = len_q;
		if (phase_q == PH_HEADER) begin
			if (pos_q == 8'd4) begin
				len_d = '0;
			end else if (pos_q >= 8'd6) begin
				case (form_cur)
					FORM_IMPLICIT: begin
						if (pos_q == 8'd6)
							len_d = {8'h00, byte_in, rep_q};
						else
							len_d = len_q | {byte_in, 24'h0};
					end
					FORM_LONG: begin
						if (pos_q >= 8'd8)
							len_d = len_q | ({24'h0, byte_in} << {pos_q[1:0], 3'b000});
					end
					default: begin
						if (pos_q == 8'd6)
							len_d = {24'h0, byte_in};
						else
							len_d = len_q | {16'h0, byte_in, 8'h00};
					end
				endcase
			end
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PREAMBLE: begin
				if (pre_last)
					phase_d = (PAPY_EN && pm_pre) ? PH_ERROR : PH_MAGIC;
			end
			PH_MAGIC: begin
				if (pos_q >= 8'd3)
					phase_d = pm_mag ? PH_HEADER : PH_ERROR;
			end
			PH_HEADER: begin
				if (go_value)
					phase_d = PH_VALUE;
			end
			PH_VALUE: begin
				if (val_done)
					phase_d = PH_HEADER;
			end
			default: phase_d = PH_ERROR;
		endcase
	end

	always_comb begin
		pos_d  = pos_q;
		pm_d   = pm_q;
		grp_d  = grp_q;
		elem_d = elem_q;
		rep_d  = rep_q;
		rem_d  = rem_q;
		fv_d   = fv_q;
		off_d  = off_q;
		cap_d  = cap_q;
		emit_d = 1'b0;
		kind_d = KIND_HEADER;
		pix_d  = '0;
		last_d = 1'b0;
		case (phase_q)
			PH_PREAMBLE: begin
				if (pre_last) begin
					pos_d = '0;
					pm_d  = 1'b1;
					if (PAPY_EN && pm_pre) begin
						emit_d = 1'b1;
						kind_d = KIND_PAPYRUS;
					end
				end else begin
					pos_d = pos_q + 8'd1;
					pm_d  = pm_pre;
				end
			end
			PH_MAGIC: begin
				pm_d = pm_mag;
				if (pos_q >= 8'd3) begin
					pos_d = '0;
					if (!pm_mag) begin
						emit_d = 1'b1;
						kind_d = KIND_NO_MAGIC;
					end
				end else begin
					pos_d = pos_q + 8'd1;
				end
			end
			PH_HEADER: begin
				case (pos_q)
					8'd0: grp_d  = {8'h00, byte_in};
					8'd1: grp_d  = {byte_in, grp_q[7:0]};
					8'd2: elem_d = {8'h00, byte_in};
					8'd3: elem_d = {byte_in, elem_q[7:0]};
					8'd4: rep_d  = {8'h00, byte_in};
					8'd5: rep_d  = {byte_in, rep_q[7:0]};
					default: ;
				endcase
				if (pos_q >= 8'd6 && hdr_end) begin
					pos_d  = '0;
					fv_d   = '0;
					off_d  = '0;
					emit_d = 1'b1;
					kind_d = KIND_HEADER;
					if (skip) begin
						rem_d = '0;
					end else if (len_d == 32'd0) begin
						rem_d = '0;
						// zero-length attribute captures as zero
						if (grp_q == IMAGE_GROUP)
							for (int i = 0; i < 5; i++)
								if (elem_q == CAP_ELEMS[i[2:0]])
									cap_d[i[2:0]] = '0;
					end else begin
						rem_d = len_d;
					end
				end else begin
					pos_d = pos_q + 8'd1;
				end
			end
			PH_VALUE: begin
				if (off_q == 2'd0)
					fv_d = {8'h00, byte_in};
				else if (off_q == 2'd1)
					fv_d = {byte_in, fv_q[7:0]};
				if (off_q != 2'd2)
					off_d = off_q + 2'd1;
				rem_d = rem_dec;
				if (val_done) begin
					pos_d = '0;
					if (grp_q == IMAGE_GROUP)
						for (int i = 0; i < 5; i++)
							if (elem_q == CAP_ELEMS[i[2:0]])
								cap_d[i[2:0]] = fv_d;
				end
				if (is_pixel) begin
					emit_d = 1'b1;
					kind_d = KIND_PIXEL;
					pix_d  = byte_in;
					last_d = val_done;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RESET;
			pos_q   <= '0;
			pm_q    <= 1'b1;
			grp_q   <= '0;
			elem_q  <= '0;
			rep_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			fv_q    <= '0;
			off_q   <= '0;
			cap_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			pm_q    <= pm_d;
			grp_q   <= grp_d;
			elem_q  <= elem_d;
			rep_q   <= rep_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			fv_q    <= fv_d;
			off_q   <= off_d;
			cap_q   <= cap_d;
		end
	end

	assign emit             = step && emit_d;
	assign res.kind         = kind_d;
	assign res.tag_group    = grp_d;
	assign res.tag_element  = elem_d;
	assign res.length_form  = (kind_d == KIND_PAPYRUS || kind_d == KIND_NO_MAGIC) ?
	                          FORM_IMPLICIT : form_of(rep_d);
	assign res.value_length = len_d;
	assign res.pixel_byte   = pix_d;
	assign res.last_pixel   = last_d;
	assign res.cap          = cap_d;

endmodule
`default_nettype wire

FILE: rtl/core/dep_out_reg.sv
`default_nettype none
module dep_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire dep_pkg::result_t   res_in,
	output logic                    free,
	output logic                    valid,
	input  wire logic               ready,
	output dep_pkg::result_t        res_q
);
	import dep_pkg::*;

	logic valid_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// hold the word until taken
	always_ff @(posedge clk) begin
		if (free && load)
			res_q <= res_in;
	end

endmodule
`default_nettype wire

FILE: rtl/core/dicom_element_stream_parser.sv
// Flow: a byte accepted into the input register is parsed once the output register is free;
//   its result word is loaded into the output register at that edge and shows on out_valid.
// Throughput: one byte per cycle while out_ready stays high; the single
//   output register stalls the input register, and so in_ready, when it is full
//   and out_ready is low.
// Reset: arst_n clears all parser state and valid flags asynchronously.
`default_nettype none
module dicom_element_stream_parser #(
	parameter int PREAMBLE_BYTES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [15:0]      tag_group,
	output logic [15:0]      tag_element,
	output logic [1:0]       length_form,
	output logic [31:0]      value_length,
	output logic [7:0]       pixel_byte,
	output logic             last_pixel,
	output logic [15:0]      rows,
	output logic [15:0]      columns,
	output logic [15:0]      samples,
	output logic [15:0]      bits_alloc,
	output logic [15:0]      pixel_repr
);
	import dep_pkg::*;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       step;
	logic       free;
	logic       emit;
	result_t    res_d;
	result_t    res_q;

	assign step     = in_valid_s1 && free;
	assign in_ready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			in_byte_s1 <= in_byte;
	end

	dep_parse_core #(
		.PREAMBLE_BYTES(PREAMBLE_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (in_byte_s1),
		.emit    (emit),
		.res     (res_d)
	);

	dep_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.res_in (res_d),
		.free   (free),
		.valid  (out_valid),
		.ready  (out_ready),
		.res_q  (res_q)
	);

	assign kind         = res_q.kind;
	assign tag_group    = res_q.tag_group;
	assign tag_element  = res_q.tag_element;
	assign length_form  = res_q.length_form;
	assign value_length = res_q.value_length;
	assign pixel_byte   = res_q.pixel_byte;
	assign last_pixel   = res_q.last_pixel;
	assign rows         = res_q.cap[0];
	assign columns      = res_q.cap[1];
	assign samples      = res_q.cap[2];
	assign bits_alloc   = res_q.cap[3];
	assign pixel_repr   = res_q.cap[4];

	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> kind == KIND_PIXEL)
		else $error("last_pixel set on a non-pixel word");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_PAPYRUS || kind == KIND_NO_MAGIC) |->
		tag_group == 16'h0 && value_length == 32'h0 && length_form == FORM_IMPLICIT)
		else $error("error word carries header fields");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> in_valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a blocked output");

endmodule
`default_nettype wire

FILE: verif/dicom_element_stream_parser_tb.sv
`timescale 1ns / 100ps
module dicom_element_stream_parser_tb;
	import dep_pkg::*;

	localparam int PREAMBLE_LEN   = 128;
	localparam int STREAM_BYTES   = 700;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic [31:0] UNDEF_LEN = 32'hFFFF_FFFF;
	localparam logic [15:0] ITEM_GRP  = 16'hFFFE;
	localparam logic [15:0] ITEM_ELM  = 16'hE000;
	localparam logic [15:0] IMAGE_GRP = 16'h0028;
	localparam logic [15:0] PIXEL_GRP = 16'h7FE0;
	localparam logic [15:0] PIXEL_ELM = 16'h0010;
	// rows, columns, samples per pixel, bits allocated, pixel representation
	localparam logic [0:4][15:0] ATTR_ELM = {16'h0010, 16'h0011, 16'h0002, 16'h0100, 16'h0103};
	localparam logic [0:6][7:0] PAPYRUS_CH = "PAPYRUS";
	localparam logic [0:3][7:0] DICM_CH    = "DICM";

	typedef struct packed {
		logic [1:0]       kind;
		logic [15:0]      grp;
		logic [15:0]      elm;
		logic [1:0]       form;
		logic [31:0]      vlen;
		logic [7:0]       pix;
		logic             last;
		logic [4:0][15:0] attr;
	} parse_word_t;

	typedef struct packed {
		logic [7:0] value;
		logic [2:0] gap;
		logic       hold;
	} stream_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = 8'h00;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  kind;
	logic [15:0] tag_group;
	logic [15:0] tag_element;
	logic [1:0]  length_form;
	logic [31:0] value_length;
	logic [7:0]  pixel_byte;
	logic        last_pixel;
	logic [15:0] rows;
	logic [15:0] columns;
	logic [15:0] samples;
	logic [15:0] bits_alloc;
	logic [15:0] pixel_repr;

	dicom_element_stream_parser #(
		.PREAMBLE_BYTES(PREAMBLE_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.tag_group(tag_group),
		.tag_element(tag_element),
		.length_form(length_form),
		.value_length(value_length),
		.pixel_byte(pixel_byte),
		.last_pixel(last_pixel),
		.rows(rows),
		.columns(columns),
		.samples(samples),
		.bits_alloc(bits_alloc),
		.pixel_repr(pixel_repr)
	);

	always #2 clk = ~clk;

	stream_byte_t stream_bytes[$];
	parse_word_t  expected_words[$];
	int           fail_count = 0;
	int           idle_cycles = 0;
	bit           calm = 1'b0;
	bit           hold_next = 1'b0;

	// parser state mirror
	phase_t           ph = PH_PREAMBLE;
	logic [7:0]       pos = 8'd0;
	bit               text_ok = 1'b1;
	logic [15:0]      grp = 16'h0;
	logic [15:0]      elm = 16'h0;
	logic [15:0]      rep = 16'h0;
	logic [15:0]      first_val = 16'h0;
	logic [31:0]      len = 32'h0;
	logic [31:0]      left = 32'h0;
	logic [4:0][15:0] attr = '0;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		if (b >= "a" && b <= "z")
			return b - 8'd32;
		return b;
	endfunction

	function automatic bit is_upper(input logic [7:0] b);
		return b >= "A" && b <= "Z";
	endfunction

	// rep holds the first code byte in its low half
	function automatic form_t code_length_form(input logic [15:0] code);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = code[7:0];
		hi = code[15:8];
		if (!(is_upper(lo) && is_upper(hi)) && !(lo == " " && hi != 8'h00))
			return FORM_IMPLICIT;
		if ((lo == "O" && (hi == "B" || hi == "W")) || (lo == "S" && hi == "Q") ||
		    (lo == "U" && hi == "N"))
			return FORM_LONG;
		return FORM_SHORT;
	endfunction

	function automatic string fmt_word(input parse_word_t w);
		return $sformatf("kind %0d tag %h,%h form %0d len %h pix %h last %b attr %h",
			w.kind, w.grp, w.elm, w.form, w.vlen, w.pix, w.last, w.attr);
	endfunction

	task automatic push_word(input kind_t k, input logic [7:0] pix, input logic last);
		parse_word_t w;
		w.kind = k;
		w.grp  = grp;
		w.elm  = elm;
		w.form = (k == KIND_PAPYRUS || k == KIND_NO_MAGIC) ? FORM_IMPLICIT : code_length_form(rep);
		w.vlen = len;
		w.pix  = pix;
		w.last = last;
		w.attr = attr;
		expected_words.push_back(w);
	endtask

	task automatic store_attr();
		if (grp == IMAGE_GRP)
			for (int i = 0; i < 5; i++)
				if (elm == ATTR_ELM[i[2:0]])
					attr[i[2:0]] = first_val;
	endtask

	task automatic predict_byte(input logic [7:0] b);
		form_t       f;
		logic [7:0]  p;
		logic [7:0]  stop;
		logic [31:0] off;
		bit          pix;
		case (ph)
			PH_PREAMBLE: begin
				if (pos < 7 && upcase(b) != PAPYRUS_CH[pos[2:0]])
					text_ok = 1'b0;
				if (pos + 1 >= PREAMBLE_LEN) begin
					pos = 8'd0;
					if (PREAMBLE_LEN >= 7 && text_ok) begin
						text_ok = 1'b1;
						ph = PH_ERROR;
						push_word(KIND_PAPYRUS, 8'h00, 1'b0);
					end else begin
						text_ok = 1'b1;
						ph = PH_MAGIC;
					end
				end else begin
					pos = pos + 8'd1;
				end
			end
			PH_MAGIC: begin
				if (upcase(b) != DICM_CH[pos[1:0]])
					text_ok = 1'b0;
				if (pos >= 3) begin
					pos = 8'd0;
					if (!text_ok) begin
						ph = PH_ERROR;
						push_word(KIND_NO_MAGIC, 8'h00, 1'b0);
					end else begin
						ph = PH_HEADER;
					end
				end else begin
					pos = pos + 8'd1;
				end
			end
			PH_HEADER: begin
				p = pos;
				case (p)
					8'd0: grp = {8'h00, b};
					8'd1: grp[15:8] = b;
					8'd2: elm = {8'h00, b};
					8'd3: elm[15:8] = b;
					8'd4: begin
						rep = {8'h00, b};
						len = 32'h0;
					end
					8'd5: rep[15:8] = b;
					default: ;
				endcase
				if (p < 6) begin
					pos = p + 8'd1;
				end else begin
					f = code_length_form(rep);
					case (f)
						FORM_IMPLICIT: begin
							if (p == 6)
								len = {8'h00, b, rep};
							else
								len[31:24] = b;
							stop = 8'd7;
						end
						FORM_LONG: begin
							// bytes 6 and 7 are reserved
							if (p >= 8)
								len = len | ({24'h0, b} << (8 * ((p - 8'd8) & 8'd3)));
							stop = 8'd11;
						end
						default: begin
							if (p == 6)
								len = {24'h0, b};
							else
								len[15:8] = b;
							stop = 8'd7;
						end
					endcase
					if (p < stop) begin
						pos = p + 8'd1;
					end else begin
						pos = 8'd0;
						first_val = 16'h0;
						if (len == UNDEF_LEN || (grp == ITEM_GRP && elm == ITEM_ELM)) begin
							left = 32'h0;
						end else if (len == 32'h0) begin
							left = 32'h0;
							store_attr();
						end else begin
							left = len;
							ph = PH_VALUE;
						end
						push_word(KIND_HEADER, 8'h00, 1'b0);
					end
				end
			end
			PH_VALUE: begin
				off = len - left;
				pix = grp == PIXEL_GRP && elm == PIXEL_ELM;
				if (off == 0)
					first_val = {8'h00, b};
				else if (off == 1)
					first_val[15:8] = b;
				left = left - 32'd1;
				if (left == 0) begin
					store_attr();
					ph = PH_HEADER;
					pos = 8'd0;
				end
				if (pix)
					push_word(KIND_PIXEL, b, left == 0);
			end
			default: ;
		endcase
	endtask

	task automatic put_byte(input logic [7:0] v);
		stream_byte_t s;
		s.value = v;
		s.gap = calm ? 3'd0 : 3'($urandom_range(7, 0));
		s.hold = hold_next;
		hold_next = 1'b0;
		stream_bytes.push_back(s);
	endtask

	// implicit form: code must equal n[15:0]; short form: n below 65536
	task automatic put_element(input logic [15:0] g, input logic [15:0] e,
	                           input logic [15:0] code, input logic [31:0] n);
		form_t f;
		f = code_length_form(code);
		put_byte(g[7:0]);
		put_byte(g[15:8]);
		put_byte(e[7:0]);
		put_byte(e[15:8]);
		put_byte(code[7:0]);
		put_byte(code[15:8]);
		case (f)
			FORM_IMPLICIT: begin
				put_byte(n[23:16]);
				put_byte(n[31:24]);
			end
			FORM_LONG: begin
				put_byte(8'($urandom_range(255, 0)));
				put_byte(8'($urandom_range(255, 0)));
				for (int i = 0; i < 4; i++)
					put_byte(n[8 * i +: 8]);
			end
			default: begin
				put_byte(n[7:0]);
				put_byte(n[15:8]);
			end
		endcase
		if (n != UNDEF_LEN && !(g == ITEM_GRP && e == ITEM_ELM))
			repeat (n) put_byte(8'($urandom_range(255, 0)));
	endtask

	// n stays below 256 so the implicit choice decodes back to n
	function automatic logic [15:0] vr_pick(input logic [31:0] n);
		logic [7:0] lo;
		logic [7:0] hi;
		case ($urandom_range(7, 0))
			0: return {"B", "O"};
			1: return {"W", "O"};
			2: return {"Q", "S"};
			3: return {"N", "U"};
			4: begin
				lo = 8'($urandom_range(8'h5A, 8'h41));
				hi = 8'($urandom_range(8'h5A, 8'h41));
				return {hi, lo};
			end
			5: begin
				hi = 8'($urandom_range(255, 1));
				return {hi, " "};
			end
			6: return n[15:0];
			default: return {"S", "U"};
		endcase
	endfunction

	// driver: predicts each accepted byte
	int           gap_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
			gap_cnt = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(in_byte);
				void'(stream_bytes.pop_front());
				if (stream_bytes.size() != 0)
					gap_cnt = int'(stream_bytes[0].gap);
			end
			if (!in_valid || in_ready) begin
				if (gap_cnt != 0) begin
					gap_cnt--;
					in_valid <= 1'b0;
				end else if (stream_bytes.size() != 0 &&
				             !(stream_bytes[0].hold && expected_words.size() != 0)) begin
					in_valid <= 1'b1;
					in_byte <= stream_bytes[0].value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted word against the oldest prediction
	int          stall_cnt = 0;
	bit          out_calm = 1'b0;
	parse_word_t got;
	parse_word_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {kind, tag_group, tag_element, length_form, value_length, pixel_byte,
				       last_pixel, pixel_repr, bits_alloc, samples, columns, rows};
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: %s", fmt_word(got));
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got.kind !== want.kind || got.grp !== want.grp ||
					    got.elm !== want.elm || got.form !== want.form ||
					    got.vlen !== want.vlen || got.pix !== want.pix ||
					    got.last !== want.last || got.attr !== want.attr) begin
						if (fail_count < 10) begin
							$display("word mismatch");
							$display("  expected %s", fmt_word(want));
							$display("  actual   %s", fmt_word(got));
						end
						fail_count++;
					end
				end
				if ($urandom_range(31, 0) == 0)
					out_calm = !out_calm;
				stall_cnt = out_calm ? 0 : $urandom_range(7, 0);
			end
			if (stall_cnt != 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[dicom_element_stream_parser] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [15:0] g;
		logic [15:0] e;
		logic [15:0] r;
		logic [31:0] n;
		int          sel;

		// preamble that almost spells the papyrus marker, then mixed-case magic
		put_byte("p");
		put_byte("a");
		put_byte("P");
		put_byte("y");
		put_byte("r");
		put_byte("u");
		put_byte("t");
		repeat (PREAMBLE_LEN - 7) put_byte(8'($urandom_range(255, 0)));
		put_byte("d");
		put_byte("I");
		put_byte("c");
		put_byte("M");

		put_element(IMAGE_GRP, ATTR_ELM[0], {"S", "U"}, 32'd2);
		put_element(IMAGE_GRP, ATTR_ELM[1], {"S", "U"}, 32'd1);
		put_element(IMAGE_GRP, ATTR_ELM[2], 16'd2, 32'd2);
		put_element(IMAGE_GRP, ATTR_ELM[3], {"B", "O"}, 32'd3);
		put_element(IMAGE_GRP, ATTR_ELM[4], {"S", "U"}, 32'd2);
		put_element(IMAGE_GRP, ATTR_ELM[4], {"S", "U"}, 32'd0);
		put_element(16'h0008, 16'h0000, {"Q", "S"}, UNDEF_LEN);
		put_element(ITEM_GRP, ITEM_ELM, {"N", "U"}, 32'h89AB_CDEF);
		put_element(16'h0010, 16'h0010, {"A", " "}, 32'd3);
		put_element(PIXEL_GRP, PIXEL_ELM, {"W", "O"}, 32'd4);
		put_element(PIXEL_GRP, PIXEL_ELM, 16'd1, 32'd1);
		hold_next = 1'b1;
		put_element(16'hFFFF, 16'hFFFF, 16'hFFFF, UNDEF_LEN);
		put_element(16'h0000, 16'h0000, {"S", "U"}, 32'd0);

		while (stream_bytes.size() < STREAM_BYTES) begin
			calm = $urandom_range(3, 0) == 0;
			if ($urandom_range(39, 0) == 0)
				hold_next = 1'b1;
			sel = $urandom_range(99, 0);
			if (sel < 25) begin
				e = ($urandom_range(5, 0) == 0) ? 16'($urandom) :
				    ATTR_ELM[3'($urandom_range(4, 0))];
				n = $urandom_range(4, 0);
				put_element(IMAGE_GRP, e, vr_pick(n), n);
			end else if (sel < 45) begin
				n = $urandom_range(24, 0);
				case ($urandom_range(2, 0))
					0: r = {"W", "O"};
					1: r = {"B", "O"};
					default: r = n[15:0];
				endcase
				put_element(PIXEL_GRP, PIXEL_ELM, r, n);
			end else if (sel < 70) begin
				n = $urandom_range(16, 0);
				put_element(16'($urandom), 16'($urandom), vr_pick(n), n);
			end else if (sel < 78) begin
				case ($urandom_range(4, 0))
					0: r = {"B", "O"};
					1: r = {"W", "O"};
					2: r = {"Q", "S"};
					3: r = {"N", "U"};
					default: r = 16'hFFFF;
				endcase
				put_element(16'($urandom), 16'($urandom), r, UNDEF_LEN);
			end else if (sel < 86) begin
				n = $urandom;
				if ($urandom_range(1, 0)) begin
					put_element(ITEM_GRP, ITEM_ELM, {"Q", "S"}, n);
				end else begin
					while (code_length_form(n[15:0]) != FORM_IMPLICIT)
						n = $urandom;
					put_element(ITEM_GRP, ITEM_ELM, n[15:0], n);
				end
			end else begin
				// noise: arbitrary tag and code bytes, length kept short
				g = 16'($urandom);
				e = 16'($urandom);
				r = 16'($urandom);
				if (code_length_form(r) == FORM_IMPLICIT) begin
					r[15:8] = 8'h00;
					n = {16'h0, r};
				end else begin
					n = $urandom_range(20, 0);
				end
				put_element(g, e, r, n);
			end
		end

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (stream_bytes.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[dicom_element_stream_parser] OK");
		else
			$display("[dicom_element_stream_parser] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/dep_pkg.sv
rtl/core/dep_parse_core.sv
rtl/core/dep_out_reg.sv
rtl/core/dicom_element_stream_parser.sv
verif/dicom_element_stream_parser_tb.sv
